### src/lbvs_pkg.sv
package lbvs_pkg;

    // palette geometry
    localparam int BONES       = 256;
    localparam int INFLUENCES  = 4;
    localparam int MAX_INFL    = 4;
    localparam int WORDS       = 21;
    localparam int ROT_BASE    = 12;
    localparam int AFF_COLS    = 4;
    localparam int BONE_AW     = (BONES > 1) ? $clog2(BONES) : 1;

    // datapath widths
    localparam int LANES       = 6;
    localparam int PROD_W      = 48;
    localparam int ROW_W       = 49;
    localparam int WROW_W      = 58;
    localparam int ACC_W       = 60;
    localparam int MAG_W       = 60;

    // divide by 255: base-256 digit sum, then remainder correction
    localparam int WEIGHT_FULL = 255;
    localparam int DIV_LO      = 4;
    localparam int DIV_HI      = (MAG_W - 1) / 8;
    localparam int REM_W       = 12;
    localparam int CORR        = DIV_HI + 1;
    localparam int CNT_W       = 4;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // pipeline depth, output register is the last stage
    localparam int NSTG        = 11;

    localparam logic KIND_TABLE  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         table_bone;
        logic [4:0]         table_element;
        logic signed [31:0] table_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [31:0]        bone_ids;
        logic [31:0]        bone_weights;
    } t_vtx_req;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_nrm_x;
        logic signed [31:0] out_nrm_y;
        logic signed [31:0] out_nrm_z;
    } t_res;

endpackage

### src/lbvs_chan_if.sv
interface lbvs_in_if;
    import lbvs_pkg::*;
    logic     valid;
    logic     ready;
    t_vtx_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbvs_out_if;
    import lbvs_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/linear_blend_vertex_skinning.sv
// Channel   Dir  Payload                                   Accepted when
// i_vtx     in   palette write or vertex (t_vtx_req)       i_vtx.valid && i_vtx.ready
// o_res     out  skinned position and normal (t_res)       o_res.valid && o_res.ready
//
// One request per cycle unless a full pipeline is stalled at the output; a vertex
// result passes through the 11-stage datapath (palette read, multiply, row sum, weight
// multiply, influence sum, magnitude, four divide-by-255 steps, saturate).
// Palette writes take effect at acceptance and produce no result.
// Synchronous active-low reset clears the stage valid bits only; palette is
// undefined until written. Each stage holds while the next is full and
// stalled, so empty stages keep filling while the output waits.
module linear_blend_vertex_skinning (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbvs_in_if.sink     i_vtx,
    lbvs_out_if.source  o_res
);
    import lbvs_pkg::*;

    logic [NSTG-1:0] en;
    logic [NSTG-1:0] r_vld;
    logic            acc_in;
    logic            wr_ok;

    // stage enables: a stage advances when empty or when its successor advances
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_vtx.ready = en[0];
    assign acc_in      = i_vtx.valid && en[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    if (k == 0) begin
                        r_vld[k] <= acc_in && (i_vtx.data.kind == KIND_VERTEX);
                    end else begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    end

    // palette: one copy per influence, one bank per matrix element
    assign wr_ok = acc_in && (i_vtx.data.kind == KIND_TABLE)
                 && ({1'b0, i_vtx.data.table_bone} < 9'(BONES))
                 && ({1'b0, i_vtx.data.table_element} < 6'(WORDS));

    logic signed [31:0] w_mat [MAX_INFL][WORDS];

    for (genvar b = 0; b < MAX_INFL; b++) begin : g_infl
        for (genvar e = 0; e < WORDS; e++) begin : g_elem
            if (b < INFLUENCES) begin : g_ram
                lbvs_ram #(
                    .WIDTH (32),
                    .DEPTH (BONES)
                ) u_ram (
                    .i_clk   (i_clk),
                    .i_we    (wr_ok && (i_vtx.data.table_element == 5'(e))),
                    .i_waddr (i_vtx.data.table_bone[BONE_AW-1:0]),
                    .i_wdata (i_vtx.data.table_value),
                    .i_re    (en[0]),
                    .i_raddr (i_vtx.data.bone_ids[8*b +: BONE_AW]),
                    .o_rdata (w_mat[b][e])
                );
            end else begin : g_none
                assign w_mat[b][e] = '0;
            end
        end
    end

    // stage 0: vertex coordinates and effective weights
    logic signed [31:0] r0_pos [3];
    logic signed [31:0] r0_nrm [3];
    logic [7:0]         r0_w   [MAX_INFL];
    logic [7:0]         n0_w   [MAX_INFL];
    logic [7:0]         bid    [MAX_INFL];

    always_comb begin
        for (int b = 0; b < MAX_INFL; b++) begin
            bid[b] = i_vtx.data.bone_ids[8*b +: 8];
            if ((b < INFLUENCES) && ({1'b0, bid[b]} < 9'(BONES))) begin
                n0_w[b] = i_vtx.data.bone_weights[8*b +: 8];
            end else begin
                n0_w[b] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_pos[0] <= i_vtx.data.pos_x;
            r0_pos[1] <= i_vtx.data.pos_y;
            r0_pos[2] <= i_vtx.data.pos_z;
            r0_nrm[0] <= i_vtx.data.nrm_x;
            r0_nrm[1] <= i_vtx.data.nrm_y;
            r0_nrm[2] <= i_vtx.data.nrm_z;
            r0_w      <= n0_w;
        end
    end

    // stage 1: matrix by coordinate products, floor shift to Q16.16
    logic signed [63:0]       s1_pp   [MAX_INFL][LANES][3];
    logic signed [PROD_W-1:0] r1_prod [MAX_INFL][LANES][3];
    logic signed [31:0]       r1_tr   [MAX_INFL][3];
    logic [7:0]               r1_w    [MAX_INFL];

    always_comb begin
        for (int b = 0; b < MAX_INFL; b++) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    s1_pp[b][r][j]   = w_mat[b][AFF_COLS*r + j] * r0_pos[j];
                    s1_pp[b][3+r][j] = w_mat[b][ROT_BASE + 3*r + j] * r0_nrm[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int b = 0; b < MAX_INFL; b++) begin
                for (int l = 0; l < LANES; l++) begin
                    for (int j = 0; j < 3; j++) begin
                        r1_prod[b][l][j] <= s1_pp[b][l][j][63:16];
                    end
                end
                for (int r = 0; r < 3; r++) begin
                    r1_tr[b][r] <= w_mat[b][AFF_COLS*r + 3];
                end
            end
            r1_w <= r0_w;
        end
    end

    // stage 2: row sums, translation on position rows
    logic signed [ROW_W-1:0] r2_row [MAX_INFL][LANES];
    logic signed [ROW_W-1:0] n2_row [MAX_INFL][LANES];
    logic [7:0]              r2_w   [MAX_INFL];

    always_comb begin
        for (int b = 0; b < MAX_INFL; b++) begin
            for (int l = 0; l < LANES; l++) begin
                n2_row[b][l] = ROW_W'(r1_prod[b][l][0]) + ROW_W'(r1_prod[b][l][1])
                             + ROW_W'(r1_prod[b][l][2]);
                if (l < 3) begin
                    n2_row[b][l] = n2_row[b][l] + ROW_W'(r1_tr[b][l]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_row <= n2_row;
            r2_w   <= r1_w;
        end
    end

    // stage 3: weight multiply, drop influences with zero weight
    logic signed [ROW_W-1:0]  s3_sel  [MAX_INFL][LANES];
    logic signed [8:0]        s3_ws   [MAX_INFL];
    logic signed [WROW_W-1:0] n3_wrow [MAX_INFL][LANES];
    logic signed [WROW_W-1:0] r3_wrow [MAX_INFL][LANES];

    always_comb begin
        for (int b = 0; b < MAX_INFL; b++) begin
            s3_ws[b] = $signed({1'b0, r2_w[b]});
            for (int l = 0; l < LANES; l++) begin
                s3_sel[b][l]  = (r2_w[b] != 8'd0) ? r2_row[b][l] : '0;
                n3_wrow[b][l] = s3_sel[b][l] * s3_ws[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_wrow <= n3_wrow;
        end
    end

    // stage 4: sum over influences
    logic signed [ACC_W-1:0] n4_acc [LANES];
    logic signed [ACC_W-1:0] r4_acc [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n4_acc[l] = '0;
            for (int b = 0; b < MAX_INFL; b++) begin
                n4_acc[l] = n4_acc[l] + ACC_W'(r3_wrow[b][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_acc <= n4_acc;
        end
    end

    // stage 5: sign and magnitude for truncating division
    logic             r5_neg [LANES];
    logic [MAG_W-1:0] r5_mag [LANES];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int l = 0; l < LANES; l++) begin
                r5_neg[l] <= r4_acc[l][ACC_W-1];
                r5_mag[l] <= r4_acc[l][ACC_W-1] ? MAG_W'(-r4_acc[l]) : MAG_W'(r4_acc[l]);
            end
        end
    end

    // stage 6: base-256 digit sums approximating mag / 255 from below
    logic [MAG_W-1:0] n6_lo  [LANES];
    logic [MAG_W-1:0] n6_hi  [LANES];
    logic [MAG_W-1:0] r6_lo  [LANES];
    logic [MAG_W-1:0] r6_hi  [LANES];
    logic [MAG_W-1:0] r6_mag [LANES];
    logic             r6_neg [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n6_lo[l] = '0;
            n6_hi[l] = '0;
            for (int k = 1; k <= DIV_HI; k++) begin
                if (k <= DIV_LO) begin
                    n6_lo[l] = n6_lo[l] + (r5_mag[l] >> (8*k));
                end else begin
                    n6_hi[l] = n6_hi[l] + (r5_mag[l] >> (8*k));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_lo  <= n6_lo;
            r6_hi  <= n6_hi;
            r6_mag <= r5_mag;
            r6_neg <= r5_neg;
        end
    end

    // stage 7: first quotient estimate
    logic [MAG_W-1:0] r7_q0  [LANES];
    logic [MAG_W-1:0] r7_mag [LANES];
    logic             r7_neg [LANES];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int l = 0; l < LANES; l++) begin
                r7_q0[l] <= r6_lo[l] + r6_hi[l];
            end
            r7_mag <= r6_mag;
            r7_neg <= r6_neg;
        end
    end

    // stage 8: remainder of the estimate, small by construction
    logic [MAG_W-1:0] s8_diff [LANES];
    logic [REM_W-1:0] r8_rem  [LANES];
    logic [MAG_W-1:0] r8_q0   [LANES];
    logic             r8_neg  [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s8_diff[l] = r7_mag[l] - ((r7_q0[l] << 8) - r7_q0[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            for (int l = 0; l < LANES; l++) begin
                r8_rem[l] <= s8_diff[l][REM_W-1:0];
            end
            r8_q0  <= r7_q0;
            r8_neg <= r7_neg;
        end
    end

    // stage 9: correct the quotient by whole multiples of 255 in the remainder
    logic [CNT_W-1:0] s9_cnt [LANES];
    logic [MAG_W-1:0] r9_q   [LANES];
    logic             r9_neg [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s9_cnt[l] = '0;
            for (int k = 1; k <= CORR; k++) begin
                if (r8_rem[l] >= REM_W'(WEIGHT_FULL * k)) begin
                    s9_cnt[l] = s9_cnt[l] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            for (int l = 0; l < LANES; l++) begin
                r9_q[l] <= r8_q0[l] + MAG_W'(s9_cnt[l]);
            end
            r9_neg <= r8_neg;
        end
    end

    // stage 10: restore sign and saturate into the output register
    logic [31:0] n10_val [LANES];
    logic [31:0] r10_val [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (!r9_neg[l]) begin
                n10_val[l] = (r9_q[l] > MAG_W'(SAT_MAX)) ? SAT_MAX : r9_q[l][31:0];
            end else begin
                n10_val[l] = (r9_q[l] > MAG_W'(SAT_MIN)) ? SAT_MIN : (32'd0 - r9_q[l][31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r10_val <= n10_val;
        end
    end

    assign o_res.valid          = r_vld[NSTG-1];
    assign o_res.data.out_pos_x = r10_val[0];
    assign o_res.data.out_pos_y = r10_val[1];
    assign o_res.data.out_pos_z = r10_val[2];
    assign o_res.data.out_nrm_x = r10_val[3];
    assign o_res.data.out_nrm_y = r10_val[4];
    assign o_res.data.out_nrm_z = r10_val[5];

    // a palette write leaves a bubble in the first stage
    a_tbl_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && (i_vtx.data.kind == KIND_TABLE)) |=> !r_vld[0])
        else $error("palette write entered the datapath");

    // an accepted vertex occupies the first stage
    a_vtx_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && (i_vtx.data.kind == KIND_VERTEX)) |=> r_vld[0])
        else $error("accepted vertex lost at entry");

    // a full, stalled pipeline takes no request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_res.ready) |-> !i_vtx.ready)
        else $error("request accepted into a full pipeline");

    // an item in stage 3 moves into an empty stage 4
    a_collapse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !r_vld[4]) |=> r_vld[4])
        else $error("item did not advance into an empty stage");

endmodule

### src/lbvs_ram.sv
module lbvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, hold while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lbvs_pkg::*;

    localparam int PAL_DEPTH  = BONES * WORDS;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 1650;
    localparam int REQ_W      = $bits(t_vtx_req);

    logic i_clk;
    logic i_rst_n;

    lbvs_in_if  vtx_if ();
    lbvs_out_if res_if ();

    linear_blend_vertex_skinning DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_if.sink),
        .o_res   (res_if.source)
    );

    // request stream and skinned results still owed by the block
    t_vtx_req    req_q[$];
    bit          drain_q[$];
    t_res        skinned_q[$];

    // palette as the predictor sees it, and what the generator has written
    logic [31:0] pal_words [0:PAL_DEPTH-1];
    bit          gen_written [0:PAL_DEPTH-1];

    int unsigned mismatches = 0;
    int unsigned vertices_done = 0;
    int unsigned table_writes = 0;
    int unsigned sat_lanes = 0;
    int unsigned idle_cycles = 0;
    int          send_gap = 0;
    int          stall_gap = 0;
    bit          calm_mode = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // short gaps mostly, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 99) return $urandom_range(15, 4);
        return $urandom_range(80, 30);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return $urandom();
            4: return $urandom();
            default: return $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] clamp_q(longint acc);
        longint q;
        q = acc / WEIGHT_FULL;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic longint pal_at(int bone, int elem);
        return longint'($signed(pal_words[bone * WORDS + elem]));
    endfunction

    // blend affine position and rotated normal over the weighted bones
    function automatic t_res skin_vertex(t_vtx_req rq);
        longint pv [3];
        longint nv [3];
        longint accp [3];
        longint accn [3];
        longint tv, tn, w;
        int bone;
        t_res rs;
        pv[0] = rq.pos_x; pv[1] = rq.pos_y; pv[2] = rq.pos_z;
        nv[0] = rq.nrm_x; nv[1] = rq.nrm_y; nv[2] = rq.nrm_z;
        for (int r = 0; r < 3; r++) begin
            accp[r] = 0;
            accn[r] = 0;
        end
        for (int b = 0; b < INFLUENCES; b++) begin
            bone = rq.bone_ids[8*b +: 8];
            w = rq.bone_weights[8*b +: 8];
            if (w == 0 || bone >= BONES) continue;
            for (int r = 0; r < 3; r++) begin
                tv = pal_at(bone, AFF_COLS * r + 3);
                tn = 0;
                for (int j = 0; j < 3; j++) begin
                    tv += (pal_at(bone, AFF_COLS * r + j) * pv[j]) >>> 16;
                    tn += (pal_at(bone, ROT_BASE + 3 * r + j) * nv[j]) >>> 16;
                end
                accp[r] += tv * w;
                accn[r] += tn * w;
            end
        end
        rs.out_pos_x = clamp_q(accp[0]);
        rs.out_pos_y = clamp_q(accp[1]);
        rs.out_pos_z = clamp_q(accp[2]);
        rs.out_nrm_x = clamp_q(accn[0]);
        rs.out_nrm_y = clamp_q(accn[1]);
        rs.out_nrm_z = clamp_q(accn[2]);
        return rs;
    endfunction

    function automatic bit bone_ready(int bone);
        for (int e = 0; e < WORDS; e++)
            if (!gen_written[bone * WORDS + e]) return 0;
        return 1;
    endfunction

    task automatic push_req(t_vtx_req rq, bit drain_first);
        if (rq.kind == KIND_TABLE && rq.table_element < WORDS)
            gen_written[rq.table_bone * WORDS + rq.table_element] = 1;
        req_q.push_back(rq);
        drain_q.push_back(drain_first);
    endtask

    function automatic t_vtx_req noise_req(logic kind);
        t_vtx_req rq;
        rq = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        rq.kind = kind;
        return rq;
    endfunction

    task automatic write_word(int bone, int elem, logic [31:0] val);
        t_vtx_req rq;
        rq = noise_req(KIND_TABLE);
        rq.table_bone = 8'(bone);
        rq.table_element = 5'(elem);
        rq.table_value = val;
        push_req(rq, 0);
    endtask

    // influence bytes: a written bone wherever the weight is nonzero
    task automatic push_vertex(int bones_ok[$], bit drain_first);
        t_vtx_req rq;
        int r;
        rq = noise_req(KIND_VERTEX);
        for (int b = 0; b < MAX_INFL; b++) begin
            r = $urandom_range(9);
            rq.bone_weights[8*b +: 8] = (r < 2) ? 8'd0 : (r < 4) ? 8'd255
                                                 : 8'($urandom_range(255));
            if (rq.bone_weights[8*b +: 8] != 0)
                rq.bone_ids[8*b +: 8] = 8'(bones_ok[$urandom_range(bones_ok.size() - 1)]);
        end
        if ($urandom_range(3) != 0) begin
            rq.pos_x = rand_word(); rq.pos_y = rand_word(); rq.pos_z = rand_word();
            rq.nrm_x = rand_word(); rq.nrm_y = rand_word(); rq.nrm_z = rand_word();
        end
        push_req(rq, drain_first);
    endtask

    // driver: hold a request until taken, then advance after a gap
    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_vtx_req nxt_data;
        nxt_valid = vtx_if.valid;
        nxt_data = vtx_if.data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (vtx_if.valid && vtx_if.ready) begin
                if (vtx_if.data.kind == KIND_VERTEX) begin
                    skinned_q.push_back(skin_vertex(vtx_if.data));
                end else begin
                    table_writes++;
                    if (vtx_if.data.table_element < WORDS)
                        pal_words[vtx_if.data.table_bone * WORDS
                                  + vtx_if.data.table_element] = vtx_if.data.table_value;
                end
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_q.size() > 0 && !(drain_q[0] && skinned_q.size() > 0)) begin
                    nxt_data = req_q.pop_front();
                    void'(drain_q.pop_front());
                    nxt_valid = 1'b1;
                    if ($urandom_range(199) == 0) calm_mode = !calm_mode;
                    send_gap = calm_mode ? 0 : gap_len();
                end
            end
        end
        vtx_if.valid <= nxt_valid;
        vtx_if.data <= nxt_data;
    end

    // monitor: random back-pressure, compare against oldest prediction
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (skinned_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = skinned_q.pop_front();
                    vertices_done++;
                    for (int k = 0; k < LANES; k++) begin
                        if (want[32*k +: 32] == SAT_MAX || want[32*k +: 32] == SAT_MIN)
                            sat_lanes++;
                        if (want[32*k +: 32] !== got[32*k +: 32]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("vertex %0d lane %0d: expected %h got %h",
                                         vertices_done, LANES - 1 - k,
                                         want[32*k +: 32], got[32*k +: 32]);
                        end
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                stall_gap = calm_mode ? 0 : gap_len();
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int bones_ok[$];
        int r;
        vtx_if.valid = 1'b0;
        vtx_if.data = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        for (int i = 0; i < PAL_DEPTH; i++) begin
            pal_words[i] = '0;
            gen_written[i] = 0;
        end

        // bone 0 identity, bone 255 full of extremes
        for (int e = 0; e < WORDS; e++) begin
            write_word(0, e, (e == 0 || e == 5 || e == 10 || e == 12 || e == 16 || e == 20)
                             ? 32'h0001_0000 : 32'h0);
            write_word(255, e, (e % 2) ? 32'h8000_0000 : 32'h7fff_ffff);
        end
        // out-of-range elements must leave the palette alone
        write_word(0, 21, 32'hdead_beef);
        write_word(255, 31, 32'h1234_5678);
        bones_ok.push_back(0);
        bones_ok.push_back(255);

        // directed vertices: zero weights, single bone, saturation, high bytes
        begin
            t_vtx_req rq;
            rq = noise_req(KIND_VERTEX);
            rq.bone_weights = 32'h0;
            push_req(rq, 0);
            rq = noise_req(KIND_VERTEX);
            rq.bone_ids = 32'hffff_ff00; rq.bone_weights = 32'h0000_00ff;
            push_req(rq, 0);
            rq.pos_x = 32'h7fff_ffff; rq.pos_y = 32'h8000_0000; rq.pos_z = 32'h7fff_ffff;
            rq.nrm_x = 32'h8000_0000; rq.nrm_y = 32'h7fff_ffff; rq.nrm_z = 32'h8000_0000;
            rq.bone_ids = 32'hffff_ffff; rq.bone_weights = 32'hffff_ffff;
            push_req(rq, 0);
            rq.bone_ids = 32'h00ff_00ff; rq.bone_weights = 32'h01fe_7f80;
            push_req(rq, 0);
            rq.pos_x = 32'h8000_0000; rq.pos_y = 32'h8000_0000; rq.pos_z = 32'h8000_0000;
            rq.bone_ids = 32'hff00_ff00; rq.bone_weights = 32'h0101_0101;
            push_req(rq, 0);
            rq.table_bone = 8'hff; rq.table_element = 5'h1f; rq.table_value = 32'hffff_ffff;
            rq.bone_ids = 32'h0000_0000; rq.bone_weights = 32'hff00_0000;
            push_req(rq, 0);
        end

        // random mix: mostly vertices over written bones, palette churn on the side
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(99);
            if (r < 28 && n != N_RANDOM / 2) begin
                int b;
                b = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15) * 17;
                write_word(b, ($urandom_range(15) == 0) ? $urandom_range(31, 21)
                                                       : $urandom_range(WORDS - 1),
                           rand_word());
                if (bone_ready(b) && !(b inside {bones_ok})) bones_ok.push_back(b);
            end else begin
                push_vertex(bones_ok, n == N_RANDOM / 2);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() > 0 || vtx_if.valid || skinned_q.size() > 0)
            @(posedge i_clk);
        repeat (3 * NSTG) @(posedge i_clk);

        $display("covered %0d palette writes and %0d skinned vertices over %0d bones",
                 table_writes, vertices_done, bones_ok.size());
        $display("%0d output lanes saturated, %0d mismatches", sat_lanes, mismatches);
        if (mismatches == 0 && skinned_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
